[rtl/mus_pkg.sv]
// shared types, constants and helpers of the medoid update select block
package mus_pkg;

	localparam int MAX_MEMBERS = 64;
	localparam int NSLOTS      = MAX_MEMBERS + 1;
	localparam int SLOT_BITS   = 7;
	localparam int DIST_BITS   = 24;
	localparam int ID_BITS     = 20;
	localparam int COST_BITS   = 40;
	localparam int THR_BITS    = 16;
	localparam int DIST_DEPTH  = NSLOTS * NSLOTS;
	localparam int DADDR_BITS  = $clog2(DIST_DEPTH);
	localparam int PROD_BITS   = COST_BITS + THR_BITS;

	localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(655);

	// action codes
	localparam logic [1:0] ACT_LOAD_ID   = 2'd0;
	localparam logic [1:0] ACT_LOAD_DIST = 2'd1;
	localparam logic [1:0] ACT_EVAL      = 2'd2;

	typedef struct packed {
		logic [1:0]           action;
		logic [SLOT_BITS-1:0] slot;
		logic [SLOT_BITS-1:0] other_slot;
		logic [ID_BITS-1:0]   point_id;
		logic [DIST_BITS-1:0] distance;
		logic [SLOT_BITS-1:0] member_count;
	} in_word_t;

	typedef struct packed {
		logic [ID_BITS-1:0]   medoid_id;
		logic [COST_BITS-1:0] min_cost;
		logic                 moved;
		logic                 last;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FETCH,
		ST_FINISH
	} seq_state_t;

	// control that travels with one distance read
	typedef struct packed {
		logic                 valid;
		logic                 first;
		logic                 row_end;
		logic                 diag;
		logic [SLOT_BITS-1:0] row;
	} acc_ctl_t;

	// end-of-evaluate phases
	typedef struct packed {
		logic fetch;
		logic finish;
	} phase_t;

	// only the upper triangle is kept: both orders of a pair map to one entry
	function automatic logic [DADDR_BITS-1:0] dist_addr(input logic [SLOT_BITS-1:0] a,
	                                                    input logic [SLOT_BITS-1:0] b);
		logic [SLOT_BITS-1:0] lo;
		logic [SLOT_BITS-1:0] hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		return DADDR_BITS'(lo) * DADDR_BITS'(NSLOTS) + DADDR_BITS'(hi);
	endfunction

endpackage

[rtl/mus_ram.sv]
// generic single-write single-read ram with registered read data
module mus_ram #(
	parameter int WIDTH     = 8,
	parameter int DEPTH     = 16,
	parameter int ADDR_BITS = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/mus_seq.sv]
// evaluate sequencer: walks every slot pair of the cluster row by row
module mus_seq (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    eval_go,
	input  logic [mus_pkg::SLOT_BITS-1:0]           member_count,
	output logic                                    busy,
	output logic                                    rd_en,
	output logic [mus_pkg::DADDR_BITS-1:0]          rd_addr,
	output mus_pkg::acc_ctl_t                       ctl_s1,
	output mus_pkg::phase_t                         phase
);

	mus_pkg::seq_state_t state_q, state_d;
	logic [mus_pkg::SLOT_BITS-1:0] r_q, l_q, n_q;
	mus_pkg::acc_ctl_t ctl;
	logic last_pair;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mus_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		busy        = (state_q != mus_pkg::ST_IDLE);
		rd_en       = (state_q == mus_pkg::ST_RUN);
		ctl.valid   = rd_en;
		ctl.first   = (l_q == '0);
		ctl.row_end = (l_q == n_q);
		ctl.diag    = (r_q == l_q);
		ctl.row     = r_q;
		last_pair   = ctl.row_end && (r_q == n_q);
		phase.fetch  = (state_q == mus_pkg::ST_FETCH);
		phase.finish = (state_q == mus_pkg::ST_FINISH);
		case (state_q)
			mus_pkg::ST_IDLE: begin
				if (eval_go) begin
					state_d = mus_pkg::ST_RUN;
				end
			end
			mus_pkg::ST_RUN: begin
				if (last_pair) begin
					state_d = mus_pkg::ST_DRAIN;
				end
			end
			mus_pkg::ST_DRAIN:  state_d = mus_pkg::ST_FETCH;
			mus_pkg::ST_FETCH:  state_d = mus_pkg::ST_FINISH;
			mus_pkg::ST_FINISH: state_d = mus_pkg::ST_IDLE;
			default:            state_d = mus_pkg::ST_IDLE;
		endcase
	end

	assign rd_addr = mus_pkg::dist_addr(r_q, l_q);

	// pair counters
	always_ff @(posedge clk) begin
		if (state_q == mus_pkg::ST_IDLE && eval_go) begin
			r_q <= '0;
			l_q <= '0;
			n_q <= (member_count > mus_pkg::SLOT_BITS'(mus_pkg::MAX_MEMBERS))
				? mus_pkg::SLOT_BITS'(mus_pkg::MAX_MEMBERS) : member_count;
		end else if (rd_en) begin
			if (ctl.row_end) begin
				l_q <= '0;
				r_q <= r_q + 1'b1;
			end else begin
				l_q <= l_q + 1'b1;
			end
		end
	end

	// control is registered alongside the ram read so that it lines up with the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

endmodule

[rtl/mus_cost.sv]
// shared saturating accumulator, best-row tracker and moved decision
module mus_cost (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mus_pkg::acc_ctl_t                   ctl_s1,
	input  logic [mus_pkg::DIST_BITS-1:0]       dist_rdata,
	input  mus_pkg::phase_t                     phase,
	input  logic [mus_pkg::THR_BITS-1:0]        threshold,
	input  logic [mus_pkg::ID_BITS-1:0]         id_rdata,
	output logic [mus_pkg::SLOT_BITS-1:0]       best_slot,
	output logic                                result_valid,
	output mus_pkg::out_word_t                  result
);

	localparam int CB = mus_pkg::COST_BITS;
	localparam int PB = mus_pkg::PROD_BITS;

	logic [CB-1:0] acc_q, obj_q, best_q, sum;
	logic [CB:0]   sum_wide;
	logic [CB-1:0] term;
	logic [mus_pkg::SLOT_BITS-1:0] best_slot_q;
	logic [PB-1:0] prod_q;
	logic [CB-1:0] diff_q;
	logic [PB-1:0] diff_shift;

	// diagonal reads as zero
	assign term     = ctl_s1.diag ? '0 : CB'(dist_rdata);
	assign sum_wide = {1'b0, (ctl_s1.first ? '0 : acc_q)} + {1'b0, term};
	assign sum      = sum_wide[CB] ? '1 : sum_wide[CB-1:0];

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			acc_q <= sum;
			if (ctl_s1.row_end) begin
				if (ctl_s1.row == '0) begin
					obj_q       <= sum;
					best_q      <= sum;
					best_slot_q <= '0;
				end else if (sum < best_q) begin
					best_q      <= sum;
					best_slot_q <= ctl_s1.row;
				end
			end
		end
	end

	assign best_slot = best_slot_q;

	// threshold product, registered here and compared in the finish phase
	always_ff @(posedge clk) begin
		if (phase.fetch) begin
			prod_q <= PB'(threshold) * PB'(obj_q);
			diff_q <= obj_q - best_q;
		end
	end

	assign diff_shift = {diff_q, {mus_pkg::THR_BITS{1'b0}}};

	always_ff @(posedge clk) begin
		if (phase.finish) begin
			result.medoid_id <= id_rdata;
			result.min_cost  <= best_q;
			result.moved     <= (obj_q == '0) || (diff_shift > prod_q);
			result.last      <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= phase.finish;
		end
	end

endmodule

[rtl/medoid_update_select_core.sv]
// top level of the medoid update select block
//
// one cluster of a k-medoids medoid update. slot 0 holds the current medoid
// id, slots 1..n the member ids; a symmetric distance table is kept between
// slots and its diagonal reads as zero.
//
// command channel: a word is taken at a clock edge with start high and busy
// low. id and distance loads never raise busy, so they can stream one per
// cycle while no evaluate holds busy high. an evaluate word raises busy
// while it runs, n being member_count clamped to 64: every slot pair is
// read once from the single read port of the distance ram and folded into
// one saturating 40-bit accumulator, then the chosen id is read and the
// moved decision is made.
//
// result channel: result_valid is high for exactly one cycle with the word
// on result; the receiver cannot stall, so nothing is held back.
// cfg_we writes change_threshold (q0.16) in the same edge; write it only
// while idle.
// reset: control state and the threshold (to 655) are cleared; ids and
// distances are undefined until loaded.
module medoid_update_select_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  mus_pkg::in_word_t                   cmd,
	input  logic                                cfg_we,
	input  logic [mus_pkg::THR_BITS-1:0]        cfg_wdata,
	output logic                                result_valid,
	output mus_pkg::out_word_t                  result
);

	logic accept;
	logic eval_go;
	logic id_we, dist_we;
	logic slot_ok, other_ok;
	logic [mus_pkg::THR_BITS-1:0]   thr_q;

	logic                            dist_re;
	logic [mus_pkg::DADDR_BITS-1:0]  dist_raddr;
	logic [mus_pkg::DIST_BITS-1:0]   dist_rdata;
	logic [mus_pkg::ID_BITS-1:0]     id_rdata;
	logic [mus_pkg::SLOT_BITS-1:0]   best_slot;
	mus_pkg::acc_ctl_t               ctl_s1;
	mus_pkg::phase_t                 phase;

	assign accept   = start && !busy;
	assign slot_ok  = (cmd.slot <= mus_pkg::SLOT_BITS'(mus_pkg::MAX_MEMBERS));
	assign other_ok = (cmd.other_slot <= mus_pkg::SLOT_BITS'(mus_pkg::MAX_MEMBERS));
	// loads to slots past the table are dropped
	assign id_we    = accept && (cmd.action == mus_pkg::ACT_LOAD_ID) && slot_ok;
	assign dist_we  = accept && (cmd.action == mus_pkg::ACT_LOAD_DIST) && slot_ok && other_ok;
	assign eval_go  = accept && (cmd.action == mus_pkg::ACT_EVAL);

	// change threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= mus_pkg::THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// slot ids, read once per evaluate for the winner
	mus_ram #(
		.WIDTH (mus_pkg::ID_BITS),
		.DEPTH (mus_pkg::NSLOTS),
		.ADDR_BITS (mus_pkg::SLOT_BITS)
	) u_id_ram (
		.clk   (clk),
		.we    (id_we),
		.waddr (cmd.slot),
		.wdata (cmd.point_id),
		.re    (phase.fetch),
		.raddr (best_slot),
		.rdata (id_rdata)
	);

	// upper-triangle distance table, one read per pair during evaluate
	mus_ram #(
		.WIDTH (mus_pkg::DIST_BITS),
		.DEPTH (mus_pkg::DIST_DEPTH),
		.ADDR_BITS (mus_pkg::DADDR_BITS)
	) u_dist_ram (
		.clk   (clk),
		.we    (dist_we),
		.waddr (mus_pkg::dist_addr(cmd.slot, cmd.other_slot)),
		.wdata (cmd.distance),
		.re    (dist_re),
		.raddr (dist_raddr),
		.rdata (dist_rdata)
	);

	mus_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.eval_go      (eval_go),
		.member_count (cmd.member_count),
		.busy         (busy),
		.rd_en        (dist_re),
		.rd_addr      (dist_raddr),
		.ctl_s1       (ctl_s1),
		.phase        (phase)
	);

	mus_cost u_cost (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_s1       (ctl_s1),
		.dist_rdata   (dist_rdata),
		.phase        (phase),
		.threshold    (thr_q),
		.id_rdata     (id_rdata),
		.best_slot    (best_slot),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
